// ===== sv/lindblad_liouvillian_term_top_defines.svh =====
// Assertion macros for the Liouvillian term block.
// Uses clk and rst_n of the module that includes it.
`ifndef LINDBLAD_LIOUVILLIAN_TERM_TOP_DEFINES_SVH
`define LINDBLAD_LIOUVILLIAN_TERM_TOP_DEFINES_SVH

`define LBT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define LBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/lbt_pkg.sv =====
// Types, codes and helpers for the Liouvillian term block.
// No dependencies.
package lbt_pkg;

  localparam logic [1:0] CMD_WR_OP   = 2'd0;
  localparam logic [1:0] CMD_WR_RHO  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic CFG_TERM_MODE  = 1'b0;
  localparam logic CFG_MATRIX_DIM = 1'b1;

  localparam int ACC_W = 66;
  localparam int WIDE_W = 72;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               sat;
  } ent_t;

  typedef struct packed {
    logic signed [32:0] re;
    logic signed [32:0] im;
    logic               sat;
  } opnd_t;

  typedef struct packed {
    logic signed [31:0] v;
    logic               c;
  } sat_t;

  typedef enum logic [1:0] {MAC_RR, MAC_II, MAC_RI, MAC_IR} mac_op_t;

  typedef struct packed {
    logic    en;
    logic    clr;
    mac_op_t op;
  } mac_ctl_t;

  typedef enum logic [2:0] {SRC_OP, SRC_OPDAG, SRC_RHO, SRC_A, SRC_B} src_t;

  typedef enum logic [2:0] {PASS_OR, PASS_RO, PASS_AD, PASS_DO, PASS_FIN} pass_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_MUL, ST_DOTEND, ST_FRD, ST_FLAT, ST_EMIT
  } state_t;

  function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
    sat_t s;
    if (v > WIDE_W'(64'sd2147483647)) begin
      s.v = 32'sh7fffffff;
      s.c = 1'b1;
    end else if (v < -WIDE_W'(64'sd2147483648)) begin
      s.v = 32'sh80000000;
      s.c = 1'b1;
    end else begin
      s.v = v[31:0];
      s.c = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== sv/lindblad_liouvillian_term_top.sv =====
// Channel   Handshake          Payload
// in        in_valid/in_stall  cmd, row/col index, value re/im
// out       out_valid/out_stall row, col, re, im, last, saturated
// cfg       cfg_we             cfg_index, cfg_wdata
// A compute runs its products over one shared multiplier. in_stall is high
// for the whole compute. An emitted entry waits in the output register while
// out_stall is high. Reset is synchronous; stores hold no reset and must be
// written before use.
// Sequencer, stores and output register; uses lbt_pkg, lbt_mem, lbt_mac.
`include "lindblad_liouvillian_term_top_defines.svh"
module lindblad_liouvillian_term_top #(
  parameter int MAX_DIM = 8,
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [2:0]         in_row_index,
  input  logic [2:0]         in_col_index,
  input  logic signed [31:0] in_value_re,
  input  logic signed [31:0] in_value_im,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_row,
  output logic [2:0]         out_col,
  output logic signed [31:0] out_re,
  output logic signed [31:0] out_im,
  output logic               out_last,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_wdata
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW = $bits(lbt_pkg::ent_t);

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(32'(r) * MAX_DIM + 32'(c));
  endfunction

  function automatic lbt_pkg::opnd_t pick(input lbt_pkg::src_t s, input lbt_pkg::ent_t op,
                                          input lbt_pkg::ent_t rho, input lbt_pkg::ent_t sa,
                                          input lbt_pkg::ent_t sb);
    lbt_pkg::ent_t  e;
    lbt_pkg::opnd_t o;
    case (s) inside
      lbt_pkg::SRC_OP, lbt_pkg::SRC_OPDAG: e = op;
      lbt_pkg::SRC_RHO: e = rho;
      lbt_pkg::SRC_A:   e = sa;
      default:          e = sb;
    endcase
    o.re  = 33'(e.re);
    o.im  = (s == lbt_pkg::SRC_OPDAG) ? -33'(e.im) : 33'(e.im);
    o.sat = e.sat;
    return o;
  endfunction

  lbt_pkg::state_t state_r, state_nxt;
  lbt_pkg::pass_t  pass_r, pass_nxt;
  logic [IW-1:0]   i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, last_r, last_nxt, dim_last_c;
  logic [2:0]      ph_r, ph_nxt;
  logic            half_r, half_nxt, f_r, f_nxt;
  lbt_pkg::ent_t   jmp_r, jmp_nxt, lft_r, lft_nxt, res_r, res_nxt;
  logic            term_mode_r;
  logic [3:0]      matrix_dim_r;

  logic            out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [2:0]      out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  lbt_pkg::ent_t   out_ent_r, out_ent_nxt;

  lbt_pkg::src_t   src_a, src_b;
  logic [AW-1:0]   ra_addr, rb_addr, waddr_ij;
  logic [EW-1:0]   op_qa, op_qb, rho_qa, rho_qb, sa_qa, sa_qb, sb_qa, sb_qb;
  lbt_pkg::opnd_t  opa, opb;
  lbt_pkg::mac_ctl_t mac_ctl;
  logic signed [lbt_pkg::ACC_W-1:0] acc_re, acc_im;
  lbt_pkg::sat_t   s_re, s_im, c_re, c_im;
  lbt_pkg::ent_t   dot_res, comb_res, p_e, q_e;
  logic            in_acc, in_range, op_we, rho_we, sa_we, sb_we;
  logic            out_free, j_end, i_end;
  logic signed [lbt_pkg::WIDE_W-1:0] half_re, half_im;

  assign in_stall = (state_r != lbt_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_range = (32'(in_row_index) < MAX_DIM) && (32'(in_col_index) < MAX_DIM);
  assign op_we    = in_acc && (in_cmd == lbt_pkg::CMD_WR_OP) && in_range;
  assign rho_we   = in_acc && (in_cmd == lbt_pkg::CMD_WR_RHO) && in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_mode_r  <= 1'b0;
      matrix_dim_r <= 4'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbt_pkg::CFG_TERM_MODE:  term_mode_r  <= cfg_wdata[0];
        lbt_pkg::CFG_MATRIX_DIM: matrix_dim_r <= cfg_wdata;
        default: term_mode_r <= term_mode_r;
      endcase
    end
  end

  always_comb begin
    if (matrix_dim_r == 4'd0) begin
      dim_last_c = '0;
    end else if (32'(matrix_dim_r) > MAX_DIM) begin
      dim_last_c = IW'(MAX_DIM - 1);
    end else begin
      dim_last_c = IW'(matrix_dim_r - 4'd1);
    end
  end

  always_comb begin
    case (pass_r)
      lbt_pkg::PASS_OR: begin src_a = lbt_pkg::SRC_OP;    src_b = lbt_pkg::SRC_RHO;   end
      lbt_pkg::PASS_RO: begin src_a = lbt_pkg::SRC_RHO;   src_b = lbt_pkg::SRC_OP;    end
      lbt_pkg::PASS_AD: begin src_a = lbt_pkg::SRC_A;     src_b = lbt_pkg::SRC_OPDAG; end
      lbt_pkg::PASS_DO: begin src_a = lbt_pkg::SRC_OPDAG; src_b = lbt_pkg::SRC_OP;    end
      default: begin
        src_a = half_r ? lbt_pkg::SRC_RHO : lbt_pkg::SRC_A;
        src_b = half_r ? lbt_pkg::SRC_A : lbt_pkg::SRC_RHO;
      end
    endcase
  end

  assign waddr_ij = addr_of(i_r, j_r);

  always_comb begin
    if (state_r == lbt_pkg::ST_FRD || state_r == lbt_pkg::ST_FLAT) begin
      ra_addr = waddr_ij;
      rb_addr = waddr_ij;
    end else begin
      ra_addr = (src_a == lbt_pkg::SRC_OPDAG) ? addr_of(k_r, i_r) : addr_of(i_r, k_r);
      rb_addr = (src_b == lbt_pkg::SRC_OPDAG) ? addr_of(j_r, k_r) : addr_of(k_r, j_r);
    end
  end

  assign sa_we = (state_r == lbt_pkg::ST_DOTEND) &&
                 (pass_r == lbt_pkg::PASS_OR || pass_r == lbt_pkg::PASS_DO);
  assign sb_we = (state_r == lbt_pkg::ST_DOTEND) &&
                 (pass_r == lbt_pkg::PASS_RO || pass_r == lbt_pkg::PASS_AD);

  lbt_mem #(.W(EW), .DEPTH(DEPTH)) u_op_store (
    .clk(clk), .we(op_we), .waddr(addr_of(IW'(in_row_index), IW'(in_col_index))),
    .wdata({in_value_re, in_value_im, 1'b0}), .ra_addr(ra_addr), .rb_addr(rb_addr),
    .qa(op_qa), .qb(op_qb)
  );

  lbt_mem #(.W(EW), .DEPTH(DEPTH)) u_rho_store (
    .clk(clk), .we(rho_we), .waddr(addr_of(IW'(in_row_index), IW'(in_col_index))),
    .wdata({in_value_re, in_value_im, 1'b0}), .ra_addr(ra_addr), .rb_addr(rb_addr),
    .qa(rho_qa), .qb(rho_qb)
  );

  lbt_mem #(.W(EW), .DEPTH(DEPTH)) u_scratch_a (
    .clk(clk), .we(sa_we), .waddr(waddr_ij), .wdata(dot_res),
    .ra_addr(ra_addr), .rb_addr(rb_addr), .qa(sa_qa), .qb(sa_qb)
  );

  lbt_mem #(.W(EW), .DEPTH(DEPTH)) u_scratch_b (
    .clk(clk), .we(sb_we), .waddr(waddr_ij), .wdata(dot_res),
    .ra_addr(ra_addr), .rb_addr(rb_addr), .qa(sb_qa), .qb(sb_qb)
  );

  assign opa = pick(src_a, op_qa, rho_qa, sa_qa, sb_qa);
  assign opb = pick(src_b, op_qb, rho_qb, sa_qb, sb_qb);

  assign mac_ctl.en  = (state_r == lbt_pkg::ST_MUL) && (ph_r < 3'd4);
  assign mac_ctl.clr = (state_r == lbt_pkg::ST_RD) && (k_r == '0);
  assign mac_ctl.op  = lbt_pkg::mac_op_t'(ph_r[1:0]);

  lbt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .rst_n(rst_n), .ctl(mac_ctl), .a(opa), .b(opb),
    .acc_re(acc_re), .acc_im(acc_im)
  );

  assign s_re = lbt_pkg::sat32(lbt_pkg::WIDE_W'(acc_re));
  assign s_im = lbt_pkg::sat32(lbt_pkg::WIDE_W'(acc_im));
  assign dot_res.re  = s_re.v;
  assign dot_res.im  = s_im.v;
  assign dot_res.sat = f_r | s_re.c | s_im.c;

  assign p_e = sa_qa;
  assign q_e = sb_qb;
  assign half_re = (lbt_pkg::WIDE_W'(lft_r.re) + lbt_pkg::WIDE_W'(dot_res.re) +
                    lbt_pkg::WIDE_W'(1)) >>> 1;
  assign half_im = (lbt_pkg::WIDE_W'(lft_r.im) + lbt_pkg::WIDE_W'(dot_res.im) +
                    lbt_pkg::WIDE_W'(1)) >>> 1;

  always_comb begin
    if (term_mode_r) begin
      c_re = lbt_pkg::sat32(lbt_pkg::WIDE_W'(jmp_r.re) - half_re);
      c_im = lbt_pkg::sat32(lbt_pkg::WIDE_W'(jmp_r.im) - half_im);
      comb_res.sat = jmp_r.sat | lft_r.sat | dot_res.sat | c_re.c | c_im.c;
    end else begin
      c_re = lbt_pkg::sat32(lbt_pkg::WIDE_W'(p_e.im) - lbt_pkg::WIDE_W'(q_e.im));
      c_im = lbt_pkg::sat32(lbt_pkg::WIDE_W'(q_e.re) - lbt_pkg::WIDE_W'(p_e.re));
      comb_res.sat = p_e.sat | q_e.sat | c_re.c | c_im.c;
    end
    comb_res.re = c_re.v;
    comb_res.im = c_im.v;
  end

  assign out_free = !out_valid_r || !out_stall;
  assign j_end    = (j_r == last_r);
  assign i_end    = (i_r == last_r);

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    ph_nxt        = ph_r;
    half_nxt      = half_r;
    f_nxt         = f_r;
    last_nxt      = last_r;
    jmp_nxt       = jmp_r;
    lft_nxt       = lft_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_ent_nxt   = out_ent_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      lbt_pkg::ST_IDLE: begin
        if (in_acc && in_cmd == lbt_pkg::CMD_COMPUTE) begin
          pass_nxt  = lbt_pkg::PASS_OR;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          last_nxt  = dim_last_c;
          state_nxt = lbt_pkg::ST_RD;
        end
      end
      lbt_pkg::ST_RD: begin
        if (k_r == '0) begin
          f_nxt = 1'b0;
        end
        ph_nxt    = '0;
        state_nxt = lbt_pkg::ST_MUL;
      end
      lbt_pkg::ST_MUL: begin
        if (ph_r == 3'd0) begin
          f_nxt = f_r | opa.sat | opb.sat;
        end
        if (ph_r == 3'd4) begin
          if (k_r == last_r) begin
            state_nxt = lbt_pkg::ST_DOTEND;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = lbt_pkg::ST_RD;
          end
        end else begin
          ph_nxt = ph_r + 3'd1;
        end
      end
      lbt_pkg::ST_DOTEND: begin
        k_nxt = '0;
        if (pass_r == lbt_pkg::PASS_FIN) begin
          if (!half_r) begin
            lft_nxt   = dot_res;
            half_nxt  = 1'b1;
            state_nxt = lbt_pkg::ST_RD;
          end else begin
            res_nxt   = comb_res;
            state_nxt = lbt_pkg::ST_EMIT;
          end
        end else begin
          state_nxt = lbt_pkg::ST_RD;
          if (!j_end) begin
            j_nxt = j_r + 1'b1;
          end else begin
            j_nxt = '0;
            if (!i_end) begin
              i_nxt = i_r + 1'b1;
            end else begin
              i_nxt = '0;
              unique case (pass_r)
                lbt_pkg::PASS_OR: pass_nxt = term_mode_r ? lbt_pkg::PASS_AD : lbt_pkg::PASS_RO;
                lbt_pkg::PASS_AD: pass_nxt = lbt_pkg::PASS_DO;
                default: begin
                  pass_nxt  = lbt_pkg::PASS_FIN;
                  state_nxt = lbt_pkg::ST_FRD;
                end
              endcase
            end
          end
        end
      end
      lbt_pkg::ST_FRD: begin
        state_nxt = lbt_pkg::ST_FLAT;
      end
      lbt_pkg::ST_FLAT: begin
        if (term_mode_r) begin
          jmp_nxt   = q_e;
          half_nxt  = 1'b0;
          k_nxt     = '0;
          state_nxt = lbt_pkg::ST_RD;
        end else begin
          res_nxt   = comb_res;
          state_nxt = lbt_pkg::ST_EMIT;
        end
      end
      lbt_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = 3'(i_r);
          out_col_nxt   = 3'(j_r);
          out_ent_nxt   = res_r;
          out_last_nxt  = i_end && j_end;
          if (i_end && j_end) begin
            state_nxt = lbt_pkg::ST_IDLE;
          end else begin
            state_nxt = lbt_pkg::ST_FRD;
            if (!j_end) begin
              j_nxt = j_r + 1'b1;
            end else begin
              j_nxt = '0;
              i_nxt = i_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = lbt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbt_pkg::ST_IDLE;
      pass_r      <= lbt_pkg::PASS_OR;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      ph_r        <= '0;
      half_r      <= 1'b0;
      last_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      ph_r        <= ph_nxt;
      half_r      <= half_nxt;
      last_r      <= last_nxt;
    end
    f_r        <= f_nxt;
    jmp_r      <= jmp_nxt;
    lft_r      <= lft_nxt;
    res_r      <= res_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_ent_r  <= out_ent_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_re        = out_ent_r.re;
  assign out_im        = out_ent_r.im;
  assign out_last      = out_last_r;
  assign out_saturated = out_ent_r.sat;

  `LBT_ASSERT_NEXT(a_compute_busy, in_acc && in_cmd == lbt_pkg::CMD_COMPUTE, state_r != lbt_pkg::ST_IDLE)
  `LBT_ASSERT_IMPL(a_mul_phase, state_r == lbt_pkg::ST_MUL, ph_r <= 3'd4)
  `LBT_ASSERT_IMPL(a_load_from_emit, $rose(out_valid_r), $past(state_r) == lbt_pkg::ST_EMIT)

endmodule

// ===== sv/lbt_mem.sv =====
// Complex entry store: one write port, two registered read ports.
// No dependencies.
module lbt_mem #(
  parameter int W = 65,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] ra_addr,
  input  logic [AW-1:0] rb_addr,
  output logic [W-1:0]  qa,
  output logic [W-1:0]  qb
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    qa <= mem[ra_addr];
    qb <= mem[rb_addr];
  end

endmodule

// ===== sv/lbt_mac.sv =====
// Shared complex multiply-accumulate unit: one real product per cycle,
// rounded and added into real or imaginary accumulator. Uses lbt_pkg.
module lbt_mac #(
  parameter int FRAC_BITS = 28
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lbt_pkg::mac_ctl_t               ctl,
  input  lbt_pkg::opnd_t                  a,
  input  lbt_pkg::opnd_t                  b,
  output logic signed [lbt_pkg::ACC_W-1:0] acc_re,
  output logic signed [lbt_pkg::ACC_W-1:0] acc_im
);

  logic signed [32:0] x, y;
  logic signed [65:0] prod_r;
  logic signed [66:0] rnd;
  lbt_pkg::mac_op_t   tag_r;
  logic               vld_r;
  logic signed [lbt_pkg::ACC_W-1:0] acc_re_r, acc_im_r;

  always_comb begin
    case (ctl.op)
      lbt_pkg::MAC_RR: begin x = a.re; y = b.re; end
      lbt_pkg::MAC_II: begin x = a.im; y = b.im; end
      lbt_pkg::MAC_RI: begin x = a.re; y = b.im; end
      default:         begin x = a.im; y = b.re; end
    endcase
  end

  assign rnd = (67'(prod_r) + (67'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl.en;
    end
    if (ctl.en) begin
      prod_r <= x * y;
      tag_r  <= ctl.op;
    end
    if (ctl.clr) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (vld_r) begin
      case (tag_r) inside
        lbt_pkg::MAC_RR: acc_re_r <= acc_re_r + lbt_pkg::ACC_W'(rnd);
        lbt_pkg::MAC_II: acc_re_r <= acc_re_r - lbt_pkg::ACC_W'(rnd);
        lbt_pkg::MAC_RI, lbt_pkg::MAC_IR: acc_im_r <= acc_im_r + lbt_pkg::ACC_W'(rnd);
        default: acc_re_r <= acc_re_r;
      endcase
    end
  end

  assign acc_re = acc_re_r;
  assign acc_im = acc_im_r;

endmodule

// ===== verif/lindblad_liouvillian_term_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lindblad_liouvillian_term_top: loads operator and
// density entries, runs commutator and dissipator computes, checks each entry.
// Depends on lbt_pkg and the block's RTL only.
module lindblad_liouvillian_term_top_tb;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int NDIM = 8;
  localparam int WDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [1:0]  cmd;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] re;
    logic [31:0] im;
  } request_t;

  typedef struct {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] re;
    logic [31:0] im;
    logic        last;
    logic        sat;
  } entry_t;

  typedef struct {
    longint re;
    longint im;
    bit     sat;
  } cval_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = '0;
  logic [2:0] in_row_index = '0;
  logic [2:0] in_col_index = '0;
  logic signed [31:0] in_value_re = '0;
  logic signed [31:0] in_value_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_row;
  logic [2:0] out_col;
  logic signed [31:0] out_re;
  logic signed [31:0] out_im;
  logic out_last;
  logic out_saturated;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [3:0] cfg_wdata = '0;

  lindblad_liouvillian_term_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_row_index(in_row_index), .in_col_index(in_col_index),
    .in_value_re(in_value_re), .in_value_im(in_value_im),
    .out_valid(out_valid), .out_stall(out_stall), .out_row(out_row),
    .out_col(out_col), .out_re(out_re), .out_im(out_im), .out_last(out_last),
    .out_saturated(out_saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  request_t request_q[$];
  entry_t   entry_q[$];

  cval_t op_mem[NDIM*NDIM];
  cval_t rho_mem[NDIM*NDIM];
  cval_t scr_a[NDIM*NDIM];
  cval_t scr_b[NDIM*NDIM];
  bit    mode_reg;
  logic [3:0] dim_reg;

  int send_idle = 0;
  int recv_stall = 0;
  int errors = 0;
  int n_requests = 0;
  int n_entries = 0;
  int n_computes = 0;
  int quiet_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint clip32(input longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint rnd_frac(input longint x);
    return (x + (64'sd1 <<< 27)) >>> 28;
  endfunction

  function automatic cval_t fetch(input lbt_pkg::src_t src, input int r, input int c);
    cval_t e;
    case (src)
      lbt_pkg::SRC_OP: e = op_mem[r*NDIM+c];
      lbt_pkg::SRC_OPDAG: begin
        e = op_mem[c*NDIM+r];
        e.im = -e.im;
      end
      lbt_pkg::SRC_RHO: e = rho_mem[r*NDIM+c];
      lbt_pkg::SRC_A: e = scr_a[r*NDIM+c];
      default: e = scr_b[r*NDIM+c];
    endcase
    return e;
  endfunction

  function automatic cval_t dot_entry(input lbt_pkg::src_t sa, input lbt_pkg::src_t sb,
                                      input int i, input int j, input int d);
    cval_t a, b, res;
    longint sr, si;
    bit f;
    sr = 0;
    si = 0;
    f = 1'b0;
    for (int k = 0; k < d; k++) begin
      a = fetch(sa, i, k);
      b = fetch(sb, k, j);
      f = f | a.sat | b.sat;
      sr += rnd_frac(a.re * b.re) - rnd_frac(a.im * b.im);
      si += rnd_frac(a.re * b.im) + rnd_frac(a.im * b.re);
    end
    res.re = clip32(sr, f);
    res.im = clip32(si, f);
    res.sat = f;
    return res;
  endfunction

  task automatic fill_scratch(input bit to_b, input lbt_pkg::src_t sa,
                              input lbt_pkg::src_t sb, input int d);
    for (int i = 0; i < d; i++)
      for (int j = 0; j < d; j++)
        if (to_b) scr_b[i*NDIM+j] = dot_entry(sa, sb, i, j, d);
        else scr_a[i*NDIM+j] = dot_entry(sa, sb, i, j, d);
  endtask

  task automatic predict_term();
    int d;
    cval_t p, q, lft, rgt;
    longint re, im;
    bit f;
    entry_t e;
    d = (dim_reg == 0) ? 1 : (dim_reg > NDIM) ? NDIM : int'(dim_reg);
    if (!mode_reg) begin
      fill_scratch(1'b0, lbt_pkg::SRC_OP, lbt_pkg::SRC_RHO, d);
      fill_scratch(1'b1, lbt_pkg::SRC_RHO, lbt_pkg::SRC_OP, d);
    end else begin
      fill_scratch(1'b0, lbt_pkg::SRC_OP, lbt_pkg::SRC_RHO, d);
      fill_scratch(1'b1, lbt_pkg::SRC_A, lbt_pkg::SRC_OPDAG, d);
      fill_scratch(1'b0, lbt_pkg::SRC_OPDAG, lbt_pkg::SRC_OP, d);
    end
    for (int i = 0; i < d; i++) begin
      for (int j = 0; j < d; j++) begin
        p = scr_a[i*NDIM+j];
        q = scr_b[i*NDIM+j];
        if (!mode_reg) begin
          f = p.sat | q.sat;
          re = clip32(p.im - q.im, f);
          im = clip32(-(p.re - q.re), f);
        end else begin
          lft = dot_entry(lbt_pkg::SRC_A, lbt_pkg::SRC_RHO, i, j, d);
          rgt = dot_entry(lbt_pkg::SRC_RHO, lbt_pkg::SRC_A, i, j, d);
          f = q.sat | lft.sat | rgt.sat;
          re = clip32(q.re - ((lft.re + rgt.re + 1) >>> 1), f);
          im = clip32(q.im - ((lft.im + rgt.im + 1) >>> 1), f);
        end
        e.row = i[2:0];
        e.col = j[2:0];
        e.re = re[31:0];
        e.im = im[31:0];
        e.last = (i == d-1 && j == d-1);
        e.sat = f;
        entry_q.push_back(e);
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
      if (!in_valid || !in_stall) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          request_t r;
          r = request_q.pop_front();
          in_valid <= 1'b1;
          in_cmd <= r.cmd;
          in_row_index <= r.row;
          in_col_index <= r.col;
          in_value_re <= r.re;
          in_value_im <= r.im;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      mode_reg <= 1'b0;
      dim_reg <= 4'd2;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lbt_pkg::CFG_TERM_MODE) mode_reg <= cfg_wdata[0];
        else dim_reg <= cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        cval_t v;
        n_requests++;
        v.re = longint'(in_value_re);
        v.im = longint'(in_value_im);
        v.sat = 1'b0;
        case (in_cmd)
          lbt_pkg::CMD_WR_OP: op_mem[in_row_index*NDIM+in_col_index] = v;
          lbt_pkg::CMD_WR_RHO: rho_mem[in_row_index*NDIM+in_col_index] = v;
          lbt_pkg::CMD_COMPUTE: begin
            n_computes++;
            predict_term();
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        n_entries++;
        if (entry_q.size() == 0) begin
          flag_mismatch("unexpected entry", 32'({out_row, out_col}), 32'd0);
        end else begin
          entry_t e;
          e = entry_q.pop_front();
          if (out_row !== e.row) flag_mismatch("out_row", 32'(out_row), 32'(e.row));
          if (out_col !== e.col) flag_mismatch("out_col", 32'(out_col), 32'(e.col));
          if (out_re !== e.re) flag_mismatch("out_re", out_re, e.re);
          if (out_im !== e.im) flag_mismatch("out_im", out_im, e.im);
          if (out_last !== e.last)
            flag_mismatch("out_last", 32'(out_last), 32'(e.last));
          if (out_saturated !== e.sat)
            flag_mismatch("out_saturated", 32'(out_saturated), 32'(e.sat));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("watchdog expired with %0d entries pending", entry_q.size());
      $display("lindblad_liouvillian_term_top_tb NOT OK");
      $finish;
    end
  end

  // stimulus
  bit op_wr[NDIM*NDIM];
  bit rho_wr[NDIM*NDIM];
  int plan_dim;

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000);
      2: case ($urandom_range(4))
           0: return 32'h7fff_ffff;
           1: return 32'h8000_0000;
           2: return 32'h0;
           3: return 32'h1000_0000;
           default: return 32'hffff_ffff;
         endcase
      default: return 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
    endcase
  endfunction

  task automatic push_request(input logic [1:0] cmd, input int r, input int c,
                              input logic [31:0] re, input logic [31:0] im);
    request_t q;
    q.cmd = cmd;
    q.row = r[2:0];
    q.col = c[2:0];
    q.re = re;
    q.im = im;
    request_q.push_back(q);
    if (cmd == lbt_pkg::CMD_WR_OP) op_wr[r*NDIM+c] = 1'b1;
    if (cmd == lbt_pkg::CMD_WR_RHO) rho_wr[r*NDIM+c] = 1'b1;
  endtask

  task automatic plan_compute(input bit refresh);
    for (int i = 0; i < plan_dim; i++)
      for (int j = 0; j < plan_dim; j++) begin
        if (refresh || !op_wr[i*NDIM+j])
          push_request(lbt_pkg::CMD_WR_OP, i, j, pick_value(), pick_value());
        if (refresh || !rho_wr[i*NDIM+j])
          push_request(lbt_pkg::CMD_WR_RHO, i, j, pick_value(), pick_value());
      end
    push_request(lbt_pkg::CMD_COMPUTE, $urandom_range(7), $urandom_range(7), $urandom,
                 $urandom);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (request_q.size() != 0 || in_valid || entry_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input bit mode, input logic [3:0] d);
    cfg_we <= 1'b1;
    cfg_index <= lbt_pkg::CFG_TERM_MODE;
    cfg_wdata <= {3'($urandom_range(7)), mode};
    @(posedge clk);
    cfg_index <= lbt_pkg::CFG_MATRIX_DIM;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    plan_dim = (d == 0) ? 1 : (d > NDIM) ? NDIM : int'(d);
  endtask

  initial begin
    int dims[12] = '{0, 1, 2, 3, 15, 8, 2, 3, 1, 4, 9, 2};
    int count, sel;
    plan_dim = 2;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes and odd commands at reset dimension
    push_request(lbt_pkg::CMD_WR_OP, 0, 0, 32'h7fff_ffff, 32'h8000_0000);
    push_request(lbt_pkg::CMD_WR_OP, 0, 1, 32'h8000_0000, 32'h7fff_ffff);
    push_request(lbt_pkg::CMD_WR_OP, 1, 0, 32'h0, 32'hffff_ffff);
    push_request(lbt_pkg::CMD_WR_OP, 1, 1, 32'h1000_0000, 32'h0);
    push_request(lbt_pkg::CMD_WR_RHO, 0, 0, 32'h8000_0000, 32'h8000_0000);
    push_request(lbt_pkg::CMD_WR_RHO, 0, 1, 32'h7fff_ffff, 32'h0);
    push_request(lbt_pkg::CMD_WR_RHO, 1, 0, 32'h0800_0000, 32'hf800_0000);
    push_request(lbt_pkg::CMD_WR_RHO, 1, 1, 32'h1000_0000, 32'h1000_0000);
    push_request(lbt_pkg::CMD_WR_OP, 7, 7, 32'h5555_5555, 32'haaaa_aaaa);
    push_request(lbt_pkg::CMD_WR_RHO, 7, 7, 32'haaaa_aaaa, 32'h5555_5555);
    push_request(CMD_NOP, 7, 7, 32'hffff_ffff, 32'hffff_ffff);
    push_request(lbt_pkg::CMD_COMPUTE, 0, 0, 32'h0, 32'h0);
    push_request(CMD_NOP, 0, 0, 32'h0, 32'h0);
    wait_idle();
    set_config(1'b1, 4'd2);
    push_request(lbt_pkg::CMD_COMPUTE, 7, 7, 32'hffff_ffff, 32'hffff_ffff);
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 75; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 75; end
        default: begin send_idle = 19; recv_stall = 19; end
      endcase
      set_config(p[0], dims[p][3:0]);
      count = 0;
      while (count < 16) begin
        sel = $urandom_range(99);
        if (sel < 40) begin
          push_request(2'($urandom_range(1)), $urandom_range(7), $urandom_range(7),
                       pick_value(), pick_value());
          count++;
        end else if (sel < 46) begin
          push_request(CMD_NOP, $urandom_range(7), $urandom_range(7), $urandom, $urandom);
        end else begin
          int before_n;
          before_n = request_q.size();
          plan_compute(sel >= 97);
          count += request_q.size() - before_n;
        end
      end
      plan_compute(1'b0);
      wait_idle();
    end

    $display("covered %0d requests, %0d computes, %0d result entries", n_requests,
             n_computes, n_entries);
    $display("both term modes over dimensions 1 to 8, with idle and stall phases");
    if (errors == 0)
      $display("lindblad_liouvillian_term_top_tb OK");
    else
      $display("lindblad_liouvillian_term_top_tb NOT OK");
    $finish;
  end
endmodule

// ===== lindblad_liouvillian_term_top.f =====
+incdir+sv
sv/lbt_pkg.sv
sv/lbt_mem.sv
sv/lbt_mac.sv
sv/lindblad_liouvillian_term_top.sv
verif/lindblad_liouvillian_term_top_tb.sv
